// ===== sv/bffa_pkg.sv =====
// Shared constants, types and state codes of the best-fit allocator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bffa_pkg;
    localparam int PAGE_BYTES   = 65536;
    localparam int HEADER_BYTES = 16;
    localparam int MAX_BLOCKS   = 64;
    localparam int SLOT_W       = $clog2(MAX_BLOCKS);
    localparam int COUNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int START_W      = 16;
    localparam int ROOM_W       = 17;
    localparam int WORD_W       = START_W + ROOM_W + SLOT_W;

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [ROOM_W-1:0]  room;
        logic [SLOT_W-1:0]  link;
    } rec_t;

    typedef enum logic [2:0] {
        ST_ALLOCATED  = 3'd0,
        ST_ZERO_SIZE  = 3'd1,
        ST_NO_FIT     = 3'd2,
        ST_FREED      = 3'd3,
        ST_NULL_FREE  = 3'd4,
        ST_TABLE_FULL = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_LINK_NEW,
        S_LINK_PREV,
        S_DONE
    } state_t;
endpackage
`default_nettype wire

// ===== sv/bffa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module bffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== sv/best_fit_free_list_allocator.sv =====
// Allocate walks every record in the list, free walks records up to its insertion point;
// the walk reads one record per cycle from the record RAM.
// Zero size, null free and table full skip the walk. One request at a time.
// Reset: one record (start 0, full page) as list head; record RAM needs no clearing.
// Depends on bffa_pkg and bffa_ram.
`timescale 1ns / 1ps
`default_nettype none
module best_fit_free_list_allocator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        operation,
    input  wire logic [16:0] request_size,
    input  wire logic [15:0] block_address,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      granted_address,
    output logic [2:0]       status
);
    localparam int SW = bffa_pkg::SLOT_W;
    localparam int CW = bffa_pkg::COUNT_W;

    bffa_pkg::state_t state_reg, state_next;
    logic [SW-1:0] head_reg, head_next;
    logic [CW-1:0] used_reg, used_next;
    logic          init_reg, init_next;
    logic          op_reg, op_next;
    logic [16:0]   req_reg, req_next;
    logic [15:0]   addr_reg, addr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [SW-1:0] rdq_reg;
    logic          found_reg, found_next;
    logic [17:0]   slack_reg, slack_next;
    logic [SW-1:0] best_reg, best_next;
    bffa_pkg::rec_t bword_reg, bword_next;
    logic          has_prev_reg, has_prev_next;
    logic [SW-1:0] prev_reg, prev_next;
    bffa_pkg::rec_t pword_reg, pword_next;
    logic [15:0]   res_addr_reg, res_addr_next;
    bffa_pkg::status_t res_st_reg, res_st_next;
    logic          ov_reg, ov_next;
    logic [15:0]   ga_reg, ga_next;
    logic [2:0]    st_reg, st_next;

    logic                  we;
    logic [SW-1:0]         waddr, raddr;
    bffa_pkg::rec_t        wword, rword;
    logic [bffa_pkg::WORD_W-1:0] rdata;
    logic [17:0]           need, slack;
    logic [16:0]           hdr;
    logic                  last;

    bffa_ram #(.WIDTH(bffa_pkg::WORD_W), .DEPTH(bffa_pkg::MAX_BLOCKS)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wword), .raddr(raddr), .rdata(rdata)
    );

    assign hdr = 17'(bffa_pkg::HEADER_BYTES);

    always_comb
    begin
        rword = bffa_pkg::rec_t'(rdata);
        if (init_reg && rdq_reg == '0)
        begin
            rword.start = '0;
            rword.room  = bffa_pkg::ROOM_W'(bffa_pkg::PAGE_BYTES);
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        used_next     = used_reg;
        init_next     = init_reg;
        op_next       = op_reg;
        req_next      = req_reg;
        addr_next     = addr_reg;
        cnt_next      = cnt_reg;
        found_next    = found_reg;
        slack_next    = slack_reg;
        best_next     = best_reg;
        bword_next    = bword_reg;
        has_prev_next = has_prev_reg;
        prev_next     = prev_reg;
        pword_next    = pword_reg;
        res_addr_next = res_addr_reg;
        res_st_next   = res_st_reg;
        ov_next       = ov_reg;
        ga_next       = ga_reg;
        st_next       = st_reg;
        we            = 1'b0;
        waddr         = '0;
        wword         = rword;
        raddr         = head_reg;
        in_ready      = 1'b0;
        need          = {1'b0, req_reg} + 18'(bffa_pkg::HEADER_BYTES);
        slack         = {1'b0, rword.room} - need;
        last          = (cnt_reg + CW'(1)) == used_reg;

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            bffa_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next       = operation;
                    req_next      = (request_size < hdr) ? hdr : request_size;
                    addr_next     = block_address;
                    cnt_next      = '0;
                    found_next    = 1'b0;
                    has_prev_next = 1'b0;
                    res_addr_next = '0;
                    state_next    = bffa_pkg::S_WALK;
                    if (!operation && request_size == '0)
                    begin
                        res_st_next = bffa_pkg::ST_ZERO_SIZE;
                        state_next  = bffa_pkg::S_DONE;
                    end
                    else if (operation && block_address == '0)
                    begin
                        res_st_next = bffa_pkg::ST_NULL_FREE;
                        state_next  = bffa_pkg::S_DONE;
                    end
                    else if (operation && used_reg >= CW'(bffa_pkg::MAX_BLOCKS))
                    begin
                        res_st_next = bffa_pkg::ST_TABLE_FULL;
                        state_next  = bffa_pkg::S_DONE;
                    end
                end
            end
            bffa_pkg::S_WALK:
            begin
                raddr    = rword.link;
                cnt_next = cnt_reg + CW'(1);
                if (!op_reg)
                begin
                    if ({1'b0, rword.room} >= need && (!found_reg || slack < slack_reg))
                    begin
                        found_next = 1'b1;
                        slack_next = slack;
                        best_next  = rdq_reg;
                        bword_next = rword;
                    end
                    if (last)
                    begin
                        state_next = bffa_pkg::S_LINK_PREV;
                    end
                end
                else
                begin
                    if (addr_reg < rword.start)
                    begin
                        state_next = bffa_pkg::S_LINK_NEW;
                    end
                    else
                    begin
                        has_prev_next = 1'b1;
                        prev_next     = rdq_reg;
                        pword_next    = rword;
                        if (last)
                        begin
                            state_next = bffa_pkg::S_LINK_NEW;
                        end
                    end
                end
            end
            bffa_pkg::S_LINK_NEW:
            begin
                we          = 1'b1;
                waddr       = used_reg[SW-1:0];
                wword.start = addr_reg;
                wword.room  = req_reg;
                wword.link  = has_prev_reg ? pword_reg.link : head_reg;
                if (!has_prev_reg)
                begin
                    head_next = used_reg[SW-1:0];
                end
                used_next   = used_reg + CW'(1);
                res_st_next = bffa_pkg::ST_FREED;
                state_next  = has_prev_reg ? bffa_pkg::S_LINK_PREV : bffa_pkg::S_DONE;
            end
            bffa_pkg::S_LINK_PREV:
            begin
                if (op_reg)
                begin
                    we         = 1'b1;
                    waddr      = prev_reg;
                    wword      = pword_reg;
                    wword.link = used_reg[SW-1:0] - SW'(1);
                end
                else if (found_reg)
                begin
                    we            = 1'b1;
                    waddr         = best_reg;
                    wword         = bword_reg;
                    wword.room    = bword_reg.room - req_reg;
                    res_addr_next = 16'(bword_reg.start + 16'(bword_reg.room - req_reg));
                    res_st_next   = bffa_pkg::ST_ALLOCATED;
                end
                else
                begin
                    res_st_next = bffa_pkg::ST_NO_FIT;
                end
                state_next = bffa_pkg::S_DONE;
            end
            bffa_pkg::S_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    ga_next    = res_addr_reg;
                    st_next    = res_st_reg;
                    state_next = bffa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bffa_pkg::S_IDLE;
            end
        endcase

        if (we && waddr == '0)
        begin
            init_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bffa_pkg::S_IDLE;
            head_reg  <= '0;
            used_reg  <= CW'(1);
            init_reg  <= 1'b1;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            used_reg  <= used_next;
            init_reg  <= init_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        req_reg      <= req_next;
        addr_reg     <= addr_next;
        cnt_reg      <= cnt_next;
        rdq_reg      <= raddr;
        found_reg    <= found_next;
        slack_reg    <= slack_next;
        best_reg     <= best_next;
        bword_reg    <= bword_next;
        has_prev_reg <= has_prev_next;
        prev_reg     <= prev_next;
        pword_reg    <= pword_next;
        res_addr_reg <= res_addr_next;
        res_st_reg   <= res_st_next;
        ga_reg       <= ga_next;
        st_reg       <= st_next;
    end

    assign out_valid       = ov_reg;
    assign granted_address = ga_reg;
    assign status          = st_reg;
endmodule
`default_nettype wire
